// ===== design/ate_pkg.sv =====
package ate_pkg;

  typedef logic [1:0] kind_t;
  typedef logic [1:0] pmode_t;

  localparam kind_t KIND_STATUS = 2'd0;
  localparam kind_t KIND_REPLY  = 2'd1;
  localparam kind_t KIND_CELL   = 2'd2;

  localparam pmode_t MODE_TEXT = 2'd0;
  localparam pmode_t MODE_ESC  = 2'd1;
  localparam pmode_t MODE_CSI  = 2'd2;

  localparam logic [7:0] ASC_BEL   = 8'h07;
  localparam logic [7:0] ASC_BS    = 8'h08;
  localparam logic [7:0] ASC_TAB   = 8'h09;
  localparam logic [7:0] ASC_LF    = 8'h0A;
  localparam logic [7:0] ASC_CR    = 8'h0D;
  localparam logic [7:0] ASC_ESC   = 8'h1B;
  localparam logic [7:0] ASC_SPACE = 8'h20;
  localparam logic [7:0] ASC_ZERO  = 8'h30;
  localparam logic [7:0] ASC_NINE  = 8'h39;
  localparam logic [7:0] ASC_SEMI  = 8'h3B;
  localparam logic [7:0] ASC_QUEST = 8'h3F;
  localparam logic [7:0] ASC_AT    = 8'h40;
  localparam logic [7:0] ASC_LBR   = 8'h5B;
  localparam logic [7:0] ASC_TILDE = 8'h7E;
  localparam logic [7:0] ASC_R     = 8'h52;

  localparam logic [7:0] FIN_CUU = 8'h41;
  localparam logic [7:0] FIN_CUD = 8'h42;
  localparam logic [7:0] FIN_CUF = 8'h43;
  localparam logic [7:0] FIN_CUB = 8'h44;
  localparam logic [7:0] FIN_CHA = 8'h47;
  localparam logic [7:0] FIN_VPA = 8'h64;
  localparam logic [7:0] FIN_CUP = 8'h48;
  localparam logic [7:0] FIN_HVP = 8'h66;
  localparam logic [7:0] FIN_EL  = 8'h4B;
  localparam logic [7:0] FIN_ED  = 8'h4A;
  localparam logic [7:0] FIN_DCH = 8'h50;
  localparam logic [7:0] FIN_ICH = 8'h40;
  localparam logic [7:0] FIN_DSR = 8'h6E;

  // hundreds, tens, ones of a value up to 255
  function automatic logic [11:0] to_bcd3(input logic [7:0] v);
    logic [3:0] h;
    logic [7:0] r;
    logic [15:0] q;
    logic [3:0] t;
    logic [3:0] o;
    h = (v >= 8'd200) ? 4'd2 : ((v >= 8'd100) ? 4'd1 : 4'd0);
    r = v - 8'(h * 8'd100);
    q = (16'(r) * 16'd205) >> 11;
    t = q[3:0];
    o = 4'(r - 8'(t * 8'd10));
    return {h, t, o};
  endfunction

endpackage

// ===== design/ansi_terminal_screen_engine_top.sv =====
// Terminal screen engine: host bytes in, status / reply / cell words out.
// Input channel (in_valid / in_stall): in_func 0 feeds in_data_byte to the
// ESC/CSI parser and screen; in_func 1 reads the cell at read_row/read_col.
// Output channel (out_valid / out_stall): a byte gives its reply words (cursor
// report only) and then one status word; a read gives one cell word. out_last
// marks the final word of each input word.
// The screen lives in one single-port-write, one-port-read RAM with registered
// read data. Scroll, erase, insert and delete walk the RAM one cell a
// cycle, over a run of up to SCREEN_ROWS*SCREEN_COLS cells.
// After reset the block sweeps all SCREEN_ROWS*SCREEN_COLS cells (2128 by
// default) to spaces with in_stall high; cfg writes are taken always.
// The result sits in an output register: a new input word is taken while it
// waits, and a stalled receiver only holds the next word at its emit step.
module ansi_terminal_screen_engine_top
  import ate_pkg::*;
#(
  parameter int SCREEN_ROWS = 28,
  parameter int SCREEN_COLS = 76,
  parameter int MAX_ARGS    = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_func,
  input  logic [7:0] in_data_byte,
  input  logic [4:0] in_read_row,
  input  logic [6:0] in_read_col,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_out_byte,
  output logic [4:0] out_cursor_row,
  output logic [6:0] out_cursor_col,
  output logic       out_last
);

  localparam int NC = SCREEN_ROWS * SCREEN_COLS;
  localparam int AW = $clog2(NC);
  localparam int LW = $clog2(NC + 1);
  localparam int RW = $clog2(SCREEN_ROWS);
  localparam int CW = $clog2(SCREEN_COLS);
  localparam int KW = $clog2(MAX_ARGS + 1);
  localparam int IW = $clog2(MAX_ARGS);
  localparam logic [16:0] ROWS17 = 17'(SCREEN_ROWS);
  localparam logic [16:0] COLS17 = 17'(SCREEN_COLS);

  typedef enum logic [2:0] {S_WALK, S_DRAIN, S_IDLE, S_RD, S_REPLY, S_STAT} state_t;

  function automatic logic [16:0] clampv(input logic [16:0] v, input logic [16:0] lim);
    return (v >= lim) ? lim - 17'd1 : v;
  endfunction

  logic [6:0] mem [NC];
  logic [6:0] rdata_r;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  state_t        state_r, state_nxt;
  logic [AW-1:0] w_addr_r, w_addr_nxt;
  logic [LW-1:0] w_rem_r, w_rem_nxt;
  logic [LW-1:0] w_dist_r, w_dist_nxt;
  logic          w_dir_r, w_dir_nxt;
  logic          stat_pend_r, stat_pend_nxt;
  logic          p_valid_r, p_valid_nxt;
  logic [AW-1:0] p_dst_r, p_dst_nxt;
  logic          p_src_ok_r, p_src_ok_nxt;
  logic [6:0]    p_data_r, p_data_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  pmode_t        mode_r, mode_nxt;
  logic          priv_r, priv_nxt;
  logic [15:0]   args_r [MAX_ARGS];
  logic [15:0]   args_nxt [MAX_ARGS];
  logic [KW-1:0] cnt_r, cnt_nxt;
  logic          reply_en_r;
  logic          oob_r, oob_nxt;
  logic [7:0]    rep_byte_r [10];
  logic [7:0]    rep_byte_nxt [10];
  logic [9:0]    rep_mask_r, rep_mask_nxt;
  logic [3:0]    ph_r, ph_nxt;
  logic          out_valid_r, out_valid_nxt;
  kind_t         out_kind_r, out_kind_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic [RW-1:0] out_row_r, out_row_nxt;
  logic [CW-1:0] out_col_r, out_col_nxt;
  logic          out_last_r, out_last_nxt;

  logic [6:0]    wr_data;
  logic          slot_free;

  assign wr_data   = p_src_ok_r ? rdata_r : p_data_r;
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (p_valid_r) begin
      mem[p_dst_r] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_comb begin
    logic [7:0]    c;
    logic [AW-1:0] base, cur;
    logic [16:0]   p0, p1, n17, rowx, colx;
    logic [IW-1:0] ai;
    logic [19:0]   dv;
    logic          go, scroll;
    logic [AW-1:0] g_start;
    logic [LW-1:0] g_len, g_dist, ndist;
    logic          g_dir;
    logic [11:0]   rb, cb;
    logic [3:0]    nx;

    state_nxt = state_r;
    w_addr_nxt = w_addr_r;
    w_rem_nxt = w_rem_r;
    w_dist_nxt = w_dist_r;
    w_dir_nxt = w_dir_r;
    stat_pend_nxt = stat_pend_r;
    p_valid_nxt = 1'b0;
    p_dst_nxt = p_dst_r;
    p_src_ok_nxt = p_src_ok_r;
    p_data_nxt = p_data_r;
    row_nxt = row_r;
    col_nxt = col_r;
    mode_nxt = mode_r;
    priv_nxt = priv_r;
    args_nxt = args_r;
    cnt_nxt = cnt_r;
    oob_nxt = oob_r;
    rep_byte_nxt = rep_byte_r;
    rep_mask_nxt = rep_mask_r;
    ph_nxt = ph_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt = out_kind_r;
    out_byte_nxt = out_byte_r;
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    out_last_nxt = out_last_r;
    rd_en = 1'b0;
    rd_addr = '0;

    c = in_data_byte;
    base = AW'(32'(row_r) * SCREEN_COLS);
    cur = base + AW'(col_r);
    p0 = 17'(args_r[0]);
    p1 = 17'(args_r[1]);
    n17 = (p0 == 17'd0) ? 17'd1 : p0;
    rowx = 17'(row_r);
    colx = 17'(col_r);
    ai = IW'(cnt_r - KW'(1));
    dv = 20'(args_r[ai]) * 20'd10 + 20'(c[3:0]);
    go = 1'b0;
    scroll = 1'b0;
    g_start = '0;
    g_len = LW'(NC);
    g_dist = {LW{1'b1}};
    g_dir = 1'b0;
    ndist = (n17 >= COLS17) ? LW'(SCREEN_COLS) : LW'(n17);
    rb = to_bcd3(8'(row_r) + 8'd1);
    cb = to_bcd3(8'(col_r) + 8'd1);
    nx = 4'd9;
    for (int j = 9; j >= 0; j--) begin
      if (4'(j) > ph_r && rep_mask_r[j]) begin
        nx = 4'(j);
      end
    end

    case (state_r)
      S_WALK: begin
        p_valid_nxt = 1'b1;
        p_dst_nxt = w_addr_r;
        p_src_ok_nxt = (w_dist_r < w_rem_r);
        p_data_nxt = ASC_SPACE[6:0];
        rd_en = (w_dist_r < w_rem_r);
        rd_addr = w_dir_r ? w_addr_r - AW'(w_dist_r) : w_addr_r + AW'(w_dist_r);
        w_rem_nxt = w_rem_r - LW'(1);
        w_addr_nxt = w_dir_r ? w_addr_r - AW'(1) : w_addr_r + AW'(1);
        if (w_rem_r == LW'(1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = stat_pend_r ? S_STAT : S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_func) begin
            rd_en = 1'b1;
            oob_nxt = !(in_read_row < SCREEN_ROWS && in_read_col < SCREEN_COLS);
            rd_addr = AW'(32'(in_read_row) * SCREEN_COLS + 32'(in_read_col));
            state_nxt = S_RD;
          end else begin
            state_nxt = S_STAT;
            case (mode_r)
              MODE_ESC: begin
                if (c == ASC_LBR) begin
                  mode_nxt = MODE_CSI;
                  priv_nxt = 1'b0;
                  cnt_nxt = KW'(1);
                  for (int i = 0; i < MAX_ARGS; i++) begin
                    args_nxt[i] = '0;
                  end
                end else begin
                  mode_nxt = MODE_TEXT;
                end
              end
              MODE_CSI: begin
                if (c == ASC_QUEST) begin
                  priv_nxt = 1'b1;
                end else if (c >= ASC_ZERO && c <= ASC_NINE) begin
                  args_nxt[ai] = (dv > 20'd65535) ? 16'hFFFF : dv[15:0];
                end else if (c == ASC_SEMI) begin
                  if (cnt_r < KW'(MAX_ARGS)) begin
                    cnt_nxt = cnt_r + KW'(1);
                  end
                end else if (c >= ASC_AT && c <= ASC_TILDE) begin
                  mode_nxt = MODE_TEXT;
                  if (!priv_r) begin
                    case (c)
                      FIN_CUU: row_nxt = (rowx > n17) ? RW'(rowx - n17) : '0;
                      FIN_CUD: row_nxt = RW'(clampv(rowx + n17, ROWS17));
                      FIN_CUF: col_nxt = CW'(clampv(colx + n17, COLS17));
                      FIN_CUB: col_nxt = (colx > n17) ? CW'(colx - n17) : '0;
                      FIN_CHA: col_nxt = CW'(clampv((p0 != 0) ? p0 - 17'd1 : 17'd0, COLS17));
                      FIN_VPA: row_nxt = RW'(clampv((p0 != 0) ? p0 - 17'd1 : 17'd0, ROWS17));
                      FIN_CUP, FIN_HVP: begin
                        row_nxt = RW'(clampv((p0 != 0) ? p0 - 17'd1 : 17'd0, ROWS17));
                        col_nxt = CW'(clampv((p1 != 0) ? p1 - 17'd1 : 17'd0, COLS17));
                      end
                      FIN_EL: begin
                        if (p0 == 17'd0) begin
                          go = 1'b1;
                          g_start = cur;
                          g_len = LW'(SCREEN_COLS) - LW'(col_r);
                        end else if (p0 == 17'd1) begin
                          go = 1'b1;
                          g_start = base;
                          g_len = LW'(col_r) + LW'(1);
                        end else if (p0 == 17'd2) begin
                          go = 1'b1;
                          g_start = base;
                          g_len = LW'(SCREEN_COLS);
                        end
                      end
                      FIN_ED: begin
                        go = 1'b1;
                        if (p0 == 17'd0) begin
                          g_start = cur;
                          g_len = LW'(NC) - LW'(cur);
                        end else if (p0 == 17'd1) begin
                          g_start = '0;
                          g_len = LW'(cur) + LW'(1);
                        end else begin
                          row_nxt = '0;
                          col_nxt = '0;
                        end
                      end
                      FIN_DCH: begin
                        go = 1'b1;
                        g_start = cur;
                        g_len = LW'(SCREEN_COLS) - LW'(col_r);
                        g_dist = ndist;
                      end
                      FIN_ICH: begin
                        go = 1'b1;
                        g_start = base + AW'(SCREEN_COLS - 1);
                        g_len = LW'(SCREEN_COLS) - LW'(col_r);
                        g_dist = ndist;
                        g_dir = 1'b1;
                      end
                      FIN_DSR: begin
                        if (p0 == 17'd6 && reply_en_r) begin
                          rep_byte_nxt[0] = ASC_ESC;
                          rep_byte_nxt[1] = ASC_LBR;
                          rep_byte_nxt[2] = ASC_ZERO + 8'(rb[11:8]);
                          rep_byte_nxt[3] = ASC_ZERO + 8'(rb[7:4]);
                          rep_byte_nxt[4] = ASC_ZERO + 8'(rb[3:0]);
                          rep_byte_nxt[5] = ASC_SEMI;
                          rep_byte_nxt[6] = ASC_ZERO + 8'(cb[11:8]);
                          rep_byte_nxt[7] = ASC_ZERO + 8'(cb[7:4]);
                          rep_byte_nxt[8] = ASC_ZERO + 8'(cb[3:0]);
                          rep_byte_nxt[9] = ASC_R;
                          rep_mask_nxt = {1'b1, 1'b1, cb[7:4] != 0 || cb[11:8] != 0,
                                          cb[11:8] != 0, 1'b1, 1'b1,
                                          rb[7:4] != 0 || rb[11:8] != 0, rb[11:8] != 0,
                                          1'b1, 1'b1};
                          ph_nxt = 4'd0;
                          state_nxt = S_REPLY;
                        end
                      end
                      default: begin
                      end
                    endcase
                  end
                end
              end
              default: begin
                case (c)
                  ASC_ESC: mode_nxt = MODE_ESC;
                  ASC_CR:  col_nxt = '0;
                  ASC_LF: begin
                    col_nxt = '0;
                    if (row_r == RW'(SCREEN_ROWS - 1)) begin
                      scroll = 1'b1;
                    end else begin
                      row_nxt = row_r + RW'(1);
                    end
                  end
                  ASC_BS: begin
                    if (col_r != '0) begin
                      col_nxt = col_r - CW'(1);
                    end
                  end
                  ASC_TAB: col_nxt = CW'(clampv((colx + 17'd8) & ~17'd7, COLS17));
                  ASC_BEL: begin
                  end
                  default: begin
                    if (c >= ASC_SPACE && c <= ASC_TILDE) begin
                      p_valid_nxt = 1'b1;
                      p_dst_nxt = cur;
                      p_src_ok_nxt = 1'b0;
                      p_data_nxt = c[6:0];
                      if (col_r == CW'(SCREEN_COLS - 1)) begin
                        col_nxt = '0;
                        if (row_r == RW'(SCREEN_ROWS - 1)) begin
                          scroll = 1'b1;
                        end else begin
                          row_nxt = row_r + RW'(1);
                        end
                      end else begin
                        col_nxt = col_r + CW'(1);
                      end
                    end
                  end
                endcase
              end
            endcase
            // scroll: each cell takes the one a row below, last row fills with space
            if (scroll) begin
              go = 1'b1;
              g_start = '0;
              g_len = LW'(NC);
              g_dist = LW'(SCREEN_COLS);
              g_dir = 1'b0;
            end
            if (go) begin
              w_addr_nxt = g_start;
              w_rem_nxt = g_len;
              w_dist_nxt = g_dist;
              w_dir_nxt = g_dir;
              stat_pend_nxt = 1'b1;
              state_nxt = S_WALK;
            end
          end
        end
      end
      S_RD: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt = KIND_CELL;
          out_byte_nxt = oob_r ? ASC_SPACE : {1'b0, rdata_r};
          out_row_nxt = row_r;
          out_col_nxt = col_r;
          out_last_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_REPLY: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt = KIND_REPLY;
          out_byte_nxt = rep_byte_r[ph_r];
          out_row_nxt = row_r;
          out_col_nxt = col_r;
          out_last_nxt = 1'b0;
          ph_nxt = nx;
          if (ph_r == 4'd9) begin
            state_nxt = S_STAT;
          end
        end
      end
      S_STAT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt = KIND_STATUS;
          out_byte_nxt = 8'd0;
          out_row_nxt = row_r;
          out_col_nxt = col_r;
          out_last_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_WALK;
      w_addr_r <= '0;
      w_rem_r <= LW'(NC);
      w_dist_r <= {LW{1'b1}};
      w_dir_r <= 1'b0;
      stat_pend_r <= 1'b0;
      p_valid_r <= 1'b0;
      row_r <= '0;
      col_r <= '0;
      mode_r <= MODE_TEXT;
      priv_r <= 1'b0;
      for (int i = 0; i < MAX_ARGS; i++) begin
        args_r[i] <= '0;
      end
      cnt_r <= KW'(1);
      reply_en_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      w_addr_r <= w_addr_nxt;
      w_rem_r <= w_rem_nxt;
      w_dist_r <= w_dist_nxt;
      w_dir_r <= w_dir_nxt;
      stat_pend_r <= stat_pend_nxt;
      p_valid_r <= p_valid_nxt;
      row_r <= row_nxt;
      col_r <= col_nxt;
      mode_r <= mode_nxt;
      priv_r <= priv_nxt;
      args_r <= args_nxt;
      cnt_r <= cnt_nxt;
      if (cfg_wr_en) begin
        reply_en_r <= cfg_wr_data;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_dst_r <= p_dst_nxt;
    p_src_ok_r <= p_src_ok_nxt;
    p_data_r <= p_data_nxt;
    oob_r <= oob_nxt;
    rep_byte_r <= rep_byte_nxt;
    rep_mask_r <= rep_mask_nxt;
    ph_r <= ph_nxt;
    out_kind_r <= out_kind_nxt;
    out_byte_r <= out_byte_nxt;
    out_row_r <= out_row_nxt;
    out_col_r <= out_col_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_out_byte   = out_byte_r;
  assign out_cursor_row = 5'(out_row_r);
  assign out_cursor_col = 7'(out_col_r);
  assign out_last       = out_last_r;

endmodule
